/* hdl/modbus_read_response_parser_core_defines.svh */
// assertion helpers for the parser rtl
`ifndef MODBUS_READ_RESPONSE_PARSER_CORE_DEFINES_SVH
`define MODBUS_READ_RESPONSE_PARSER_CORE_DEFINES_SVH

// clocked check, masked while reset is asserted
`define MBRP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define MBRP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/mbrp_pkg.sv */
`default_nettype none
package mbrp_pkg;

    localparam int NWORDS = 9;
    localparam int WORD_W = 16;
    localparam int KIND_W = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0] FUNC_READ = 8'h03;
    localparam logic [7:0] ADDR_RESET = 8'd80;

    localparam logic [1:0] MODE_QUAT = 2'd0;
    localparam logic [1:0] MODE_MOTION = 2'd1;
    localparam logic [1:0] MODE_CAL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_ADDR  = 3'd1,
        ST_CRC   = 3'd2,
        ST_FUNC  = 3'd3,
        ST_COUNT = 3'd4,
        ST_SHORT = 3'd5,
        ST_LONG  = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0] dev_addr;
        logic [1:0] mode;
    } t_cfg;

    typedef struct packed {
        t_status                        status;
        logic [1:0]                     mode;
        logic [NWORDS-1:0][WORD_W-1:0]  words;
    } t_desc;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

    function automatic logic [1:0] eff_mode(input logic [1:0] m);
        return (m == MODE_MOTION || m == MODE_CAL) ? m : MODE_QUAT;
    endfunction

    function automatic logic [3:0] skip_words(input logic [1:0] m);
        return (m == MODE_MOTION) ? 4'd4 : 4'd0;
    endfunction

    function automatic logic [7:0] need_bytes(input logic [1:0] m);
        case (m)
            MODE_MOTION: return 8'd26;
            MODE_CAL:    return 8'd6;
            default:     return 8'd8;
        endcase
    endfunction

    function automatic logic [3:0] word_count(input logic [1:0] m);
        case (m)
            MODE_MOTION: return 4'd9;
            MODE_CAL:    return 4'd3;
            default:     return 4'd4;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] kind_base(input logic [1:0] m);
        case (m)
            MODE_MOTION: return 4'd0;
            MODE_CAL:    return 4'd13;
            default:     return 4'd9;
        endcase
    endfunction

endpackage
`default_nettype wire

/* hdl/mbrp_byte_if.sv */
`default_nettype none
interface mbrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;

    modport source (output valid, output rx_byte, output last_byte, input ready);
    modport sink (input valid, input rx_byte, input last_byte, output ready);
endinterface
`default_nettype wire

/* hdl/mbrp_word_if.sv */
`default_nettype none
interface mbrp_word_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] word_value;
    logic [3:0]         word_kind;
    logic [2:0]         frame_status;
    logic               last_word;

    modport source (
        output valid, output word_value, output word_kind, output frame_status,
        output last_word, input ready
    );
    modport sink (
        input valid, input word_value, input word_kind, input frame_status,
        input last_word, output ready
    );
endinterface
`default_nettype wire

/* hdl/mbrp_front.sv */
`default_nettype none
module mbrp_front #(
    parameter int MAX_FRAME = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  mbrp_pkg::t_cfg      i_cfg,
    mbrp_byte_if.sink           i_rx,
    input  wire logic           i_full,
    output logic                o_push,
    output mbrp_pkg::t_desc     o_desc
);
    import mbrp_pkg::*;

    localparam int IDX_W = $clog2(MAX_FRAME + 2);

    logic [15:0]                    r_crc, n_crc;
    logic [IDX_W-1:0]               r_byte_index, n_byte_index;
    logic [7:0]                     r_function_code, n_function_code;
    logic [7:0]                     r_payload_count, n_payload_count;
    logic [7:0]                     r_pending_high, n_pending_high;
    logic                           r_addr_ok, n_addr_ok;
    logic [NWORDS-1:0][WORD_W-1:0]  r_store, n_store;

    logic             accept;
    logic [1:0]       m;
    logic [IDX_W-1:0] q;
    logic [IDX_W-1:0] w_ext;
    logic [IDX_W-1:0] s_ext;
    logic [IDX_W-1:0] w_rel;
    logic [9:0]       len10;
    t_status          status;

    assign i_rx.ready = !i_full;
    assign accept = i_rx.valid && !i_full;
    assign m = eff_mode(i_cfg.mode);

    assign q = r_byte_index - IDX_W'(3);
    assign w_ext = {1'b0, q[IDX_W-1:1]};
    assign s_ext = IDX_W'(skip_words(m));
    assign w_rel = w_ext - s_ext;

    always_comb begin
        n_crc = crc_byte(r_crc, i_rx.rx_byte);
        n_function_code = r_function_code;
        n_payload_count = r_payload_count;
        n_pending_high = r_pending_high;
        n_addr_ok = r_addr_ok;
        n_store = r_store;
        if (r_byte_index == '0) begin
            n_addr_ok = (i_rx.rx_byte == i_cfg.dev_addr);
        end else if (r_byte_index == IDX_W'(1)) begin
            n_function_code = i_rx.rx_byte;
        end else if (r_byte_index == IDX_W'(2)) begin
            n_payload_count = i_rx.rx_byte;
        end else if (r_byte_index < IDX_W'(MAX_FRAME)) begin
            if (!q[0]) begin
                n_pending_high = i_rx.rx_byte;
            end else if (w_ext >= s_ext && w_rel < IDX_W'(NWORDS)) begin
                n_store[w_rel[3:0]] = {r_pending_high, i_rx.rx_byte};
            end
        end
        // saturate one past the limit so overlong frames stay flagged
        n_byte_index = (r_byte_index <= IDX_W'(MAX_FRAME)) ? r_byte_index + IDX_W'(1)
                                                           : r_byte_index;
    end

    assign len10 = 10'(n_byte_index);

    always_comb begin
        if (len10 > 10'(MAX_FRAME)) begin
            status = ST_LONG;
        end else if (!n_addr_ok || len10 <= 10'd5) begin
            status = ST_ADDR;
        end else if (n_crc != 16'h0000) begin
            status = ST_CRC;
        end else if (n_function_code != FUNC_READ) begin
            status = ST_FUNC;
        end else if (len10 < 10'(n_payload_count) + 10'd5) begin
            status = ST_COUNT;
        end else if (n_payload_count < need_bytes(m)) begin
            status = ST_SHORT;
        end else begin
            status = ST_OK;
        end
    end

    assign o_push = accept && i_rx.last_byte;
    assign o_desc.status = status;
    assign o_desc.mode = m;
    assign o_desc.words = n_store;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
            r_byte_index <= '0;
            r_function_code <= '0;
            r_payload_count <= '0;
            r_pending_high <= '0;
            r_addr_ok <= 1'b0;
        end else if (accept) begin
            if (i_rx.last_byte) begin
                r_crc <= CRC_INIT;
                r_byte_index <= '0;
                r_function_code <= '0;
                r_payload_count <= '0;
                r_pending_high <= '0;
                r_addr_ok <= 1'b0;
            end else begin
                r_crc <= n_crc;
                r_byte_index <= n_byte_index;
                r_function_code <= n_function_code;
                r_payload_count <= n_payload_count;
                r_pending_high <= n_pending_high;
                r_addr_ok <= n_addr_ok;
            end
        end
    end

    // word store keeps its contents across frames
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_store <= n_store;
        end
    end
endmodule
`default_nettype wire

/* hdl/mbrp_queue.sv */
`default_nettype none
module mbrp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  mbrp_pkg::t_desc     i_desc,
    output logic                o_full,
    output logic                o_valid,
    output mbrp_pkg::t_desc     o_desc,
    input  wire logic           i_pop
);
    import mbrp_pkg::*;

    t_desc      r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count, n_count;

    assign o_full = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_desc = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end
endmodule
`default_nettype wire

/* hdl/mbrp_back.sv */
`default_nettype none
`include "modbus_read_response_parser_core_defines.svh"
module mbrp_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  mbrp_pkg::t_desc     i_q_desc,
    output logic                o_pop,
    mbrp_word_if.source         o_res
);
    import mbrp_pkg::*;

    t_desc      r_desc;
    logic       r_active;
    logic [3:0] r_k;

    logic       take;
    logic       done;
    logic       is_ok;
    logic [3:0] n_words;

    assign is_ok = (r_desc.status == ST_OK);
    assign n_words = word_count(r_desc.mode);

    assign o_res.valid = r_active;
    assign o_res.word_value = is_ok ? $signed(r_desc.words[r_k]) : 16'sd0;
    assign o_res.word_kind = is_ok ? kind_base(r_desc.mode) + r_k : 4'd0;
    assign o_res.frame_status = r_desc.status;
    assign o_res.last_word = is_ok ? (r_k == n_words - 4'd1) : 1'b1;

    assign take = r_active && o_res.ready;
    assign done = take && o_res.last_word;
    // next frame loads in the cycle its predecessor's final word leaves
    assign o_pop = i_q_valid && (!r_active || done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_k <= 4'd0;
        end else if (o_pop) begin
            r_active <= 1'b1;
            r_k <= 4'd0;
        end else if (done) begin
            r_active <= 1'b0;
        end else if (take) begin
            r_k <= r_k + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_q_desc;
        end
    end

    `MBRP_ASSERT(a_status_single, i_clk, i_rst_n,
        (r_active && r_desc.status != ST_OK) |-> (o_res.last_word && o_res.word_value == 16'sd0),
        "status result must be a single zero word")
    `MBRP_ASSERT(a_burst_continues, i_clk, i_rst_n,
        (take && !o_res.last_word) |=> (r_active && r_k == $past(r_k) + 4'd1),
        "frame burst broke before its final word")
    `MBRP_ASSERT(a_index_bound, i_clk, i_rst_n,
        (r_active && r_desc.status == ST_OK) |-> (r_k < n_words),
        "word index ran past the frame's word count")
endmodule
`default_nettype wire

/* hdl/modbus_read_response_parser_core.sv */
// Modbus RTU read-reply parser: bytes enter on i_rx with a last-byte mark, one byte per cycle
// whenever the two-entry frame queue has room. The CRC-16 (init FFFF, poly A001), header
// checks and word buffering run in the front end in the cycle each byte is taken; at the last
// byte a frame record with its status and the buffered words enters the queue. The back end
// sends each frame's results on o_res one per cycle while ready is high: 4 words in quaternion
// mode, 9 in motion mode, 3 in calibration mode, or one status result for a failing frame. The
// front stalls only when two finished frames are still waiting behind the one being sent.
// Config writes take effect at once and belong between frames.
`default_nettype none
module modbus_read_response_parser_core #(
    parameter int MAX_FRAME = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    mbrp_byte_if.sink                                i_rx,
    mbrp_word_if.source                              o_res,
    input  wire logic                                i_cfg_we,
    input  wire logic [mbrp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [mbrp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mbrp_pkg::*;

    t_cfg  r_cfg;
    logic  push, full, q_valid, pop;
    t_desc push_desc, q_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr <= ADDR_RESET;
            r_cfg.mode <= MODE_QUAT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEV_ADDR: r_cfg.dev_addr <= i_cfg_data;
                CFG_MODE:     r_cfg.mode <= i_cfg_data[1:0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    mbrp_front #(
        .MAX_FRAME(MAX_FRAME)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (r_cfg),
        .i_rx   (i_rx),
        .i_full (full),
        .o_push (push),
        .o_desc (push_desc)
    );

    mbrp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_desc (push_desc),
        .o_full (full),
        .o_valid(q_valid),
        .o_desc (q_desc),
        .i_pop  (pop)
    );

    mbrp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_desc (q_desc),
        .o_pop    (pop),
        .o_res    (o_res)
    );
endmodule
`default_nettype wire

/* dv/modbus_read_response_parser_core_test.sv */
`default_nettype none
module modbus_read_response_parser_core_test;
    import mbrp_pkg::*;

    localparam int MAX_FRAME = 64;
    localparam int KEEP = -1;
    localparam int SETTLE = 16;
    localparam int QUIET_LIMIT = 4000;
    localparam int TOTAL_BYTES = 460;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [7:0] FUNC_READ_INPUT = 8'h04;
    localparam logic [7:0] FUNC_READ_EXCEPTION = 8'h83;

    typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES, FILL_MAXPOS, FILL_MINNEG} t_fill;

    typedef struct packed {
        logic signed [15:0] value;
        logic [3:0]         kind;
        t_status            status;
        logic               last;
    } t_word_res;

    typedef struct {
        int      mode;
        int      addr;
        bit      bad_addr;
        int      fn;
        int      cnt;
        int      n;
        t_fill   fill;
        bit      crc_ok;
        int      trim;
        bit      typed;
        t_status want;
    } t_row;

    // mode, addr, bad addr, function, count, payload bytes, fill, crc ok, trim, typed, status
    t_row plan [23] = '{
        '{KEEP, KEEP, 0, FUNC_READ, 8, 8, FILL_MAXPOS, 1, 0, 0, ST_OK},
        '{KEEP, KEEP, 0, FUNC_READ, 8, 8, FILL_MINNEG, 1, 0, 0, ST_OK},
        '{KEEP, KEEP, 1, FUNC_READ, 8, 8, FILL_RAND, 1, 0, 1, ST_ADDR},
        '{KEEP, KEEP, 0, FUNC_READ, 8, 8, FILL_RAND, 0, 0, 1, ST_CRC},
        '{KEEP, KEEP, 1, FUNC_READ, 8, 8, FILL_RAND, 0, 0, 1, ST_ADDR},
        '{KEEP, KEEP, 0, FUNC_READ_INPUT, 8, 8, FILL_RAND, 1, 0, 1, ST_FUNC},
        '{KEEP, KEEP, 0, FUNC_READ_EXCEPTION, 8, 8, FILL_RAND, 1, 0, 1, ST_FUNC},
        '{KEEP, KEEP, 0, FUNC_READ, 9, 8, FILL_RAND, 1, 0, 1, ST_COUNT},
        '{KEEP, KEEP, 0, FUNC_READ, 255, 8, FILL_RAND, 1, 0, 1, ST_COUNT},
        '{KEEP, KEEP, 0, FUNC_READ, 6, 6, FILL_RAND, 1, 0, 1, ST_SHORT},
        '{KEEP, KEEP, 0, FUNC_READ, 0, 0, FILL_RAND, 1, 0, 1, ST_ADDR},
        '{KEEP, KEEP, 0, FUNC_READ, 8, 8, FILL_RAND, 1, 5, 1, ST_ADDR},
        '{KEEP, KEEP, 0, FUNC_READ, 62, 62, FILL_RAND, 1, 0, 1, ST_LONG},
        '{KEEP, KEEP, 0, FUNC_READ, 59, 59, FILL_ONES, 1, 0, 0, ST_OK},
        '{MODE_MOTION, KEEP, 0, FUNC_READ, 26, 26, FILL_RAND, 1, 0, 0, ST_OK},
        '{KEEP, KEEP, 0, FUNC_READ, 24, 24, FILL_RAND, 1, 0, 1, ST_SHORT},
        '{MODE_CAL, KEEP, 0, FUNC_READ, 6, 6, FILL_ONES, 1, 0, 0, ST_OK},
        '{KEEP, KEEP, 0, FUNC_READ, 4, 4, FILL_RAND, 1, 0, 1, ST_SHORT},
        '{KEEP, KEEP, 0, FUNC_READ, 1, 1, FILL_RAND, 1, 0, 1, ST_SHORT},
        '{MODE_SPARE, KEEP, 0, FUNC_READ, 8, 8, FILL_RAND, 1, 0, 0, ST_OK},
        '{MODE_QUAT, 0, 0, FUNC_READ, 8, 8, FILL_ZERO, 1, 0, 0, ST_OK},
        '{MODE_MOTION, 255, 0, FUNC_READ, 40, 40, FILL_MINNEG, 1, 0, 0, ST_OK},
        '{MODE_CAL, KEEP, 0, FUNC_READ, 7, 7, FILL_RAND, 1, 0, 0, ST_OK}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mbrp_byte_if rx_ch ();
    mbrp_word_if res_ch ();

    modbus_read_response_parser_core #(.MAX_FRAME(MAX_FRAME)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (rx_ch),
        .o_res       (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // parser state as the block should hold it
    logic [7:0]  cfg_addr;
    logic [1:0]  cfg_mode;
    logic [15:0] crc_run;
    int unsigned seen_count;
    logic [7:0]  fn_code;
    logic [7:0]  cnt_field;
    logic [7:0]  hi_byte;
    logic [15:0] word_buf [NWORDS];
    logic        addr_match;

    t_word_res   expected_words [$];
    t_word_res   frame_words [$];
    logic [7:0]  frame_bytes [$];
    int          errors;
    int          bytes_sent;
    bit          steady;

    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic logic [1:0] active_mode();
        return (cfg_mode == MODE_MOTION || cfg_mode == MODE_CAL) ? cfg_mode : MODE_QUAT;
    endfunction

    function automatic int payload_need(input logic [1:0] m);
        return (m == MODE_MOTION) ? 26 : (m == MODE_CAL) ? 6 : 8;
    endfunction

    function automatic void clear_frame();
        crc_run = CRC_INIT;
        seen_count = 0;
        fn_code = 8'h00;
        cnt_field = 8'h00;
        hi_byte = 8'h00;
        addr_match = 1'b0;
    endfunction

    // one accepted byte on the byte side; words of a finished frame land in frame_words
    function automatic void absorb_byte(input logic [7:0] b, input logic last_b);
        int unsigned pos, len, q, w, skip, n, base;
        logic [1:0] m;
        t_status st;
        t_word_res r;
        pos = seen_count;
        m = active_mode();
        crc_run = crc_step(crc_run, b);
        if (pos == 0) begin
            addr_match = (b == cfg_addr);
        end else if (pos == 1) begin
            fn_code = b;
        end else if (pos == 2) begin
            cnt_field = b;
        end else if (pos < MAX_FRAME) begin
            q = pos - 3;
            if (q[0] == 1'b0) begin
                hi_byte = b;
            end else begin
                w = q >> 1;
                skip = (m == MODE_MOTION) ? 4 : 0;
                if (w >= skip && w - skip < NWORDS) word_buf[w - skip] = {hi_byte, b};
            end
        end
        if (seen_count <= MAX_FRAME) seen_count++;
        if (!last_b) return;

        len = seen_count;
        if (len > MAX_FRAME) st = ST_LONG;
        else if (!addr_match || len <= 5) st = ST_ADDR;
        else if (crc_run != 16'h0000) st = ST_CRC;
        else if (fn_code != FUNC_READ) st = ST_FUNC;
        else if (len < cnt_field + 5) st = ST_COUNT;
        else if (cnt_field < payload_need(m)) st = ST_SHORT;
        else st = ST_OK;
        clear_frame();

        if (st != ST_OK) begin
            r = '{value: 16'sd0, kind: 4'd0, status: st, last: 1'b1};
            frame_words.push_back(r);
            return;
        end
        n = (m == MODE_MOTION) ? 9 : (m == MODE_CAL) ? 3 : 4;
        base = (m == MODE_MOTION) ? 0 : (m == MODE_CAL) ? 13 : 9;
        for (int k = 0; k < n; k++) begin
            r.value = word_buf[k];
            r.kind = 4'(base + k);
            r.status = ST_OK;
            r.last = (k == n - 1);
            frame_words.push_back(r);
        end
    endfunction

    function automatic void build_frame(input logic [7:0] addr, input logic [7:0] fn,
                                        input logic [7:0] cnt, input int n, input t_fill fill,
                                        input bit crc_ok, input int trim);
        logic [15:0] c;
        logic [7:0] v;
        frame_bytes.delete();
        frame_bytes.push_back(addr);
        frame_bytes.push_back(fn);
        frame_bytes.push_back(cnt);
        for (int i = 0; i < n; i++) begin
            case (fill)
                FILL_ZERO:   v = 8'h00;
                FILL_ONES:   v = 8'hFF;
                FILL_MAXPOS: v = i[0] ? 8'hFF : 8'h7F;
                FILL_MINNEG: v = i[0] ? 8'h00 : 8'h80;
                default:     v = 8'($urandom);
            endcase
            frame_bytes.push_back(v);
        end
        c = CRC_INIT;
        foreach (frame_bytes[i]) c = crc_step(c, frame_bytes[i]);
        if (!crc_ok) c = c ^ (16'h0001 << $urandom_range(15, 0));
        // crc goes out low byte first
        frame_bytes.push_back(c[7:0]);
        frame_bytes.push_back(c[15:8]);
        if (trim > 0) begin
            while (frame_bytes.size() > trim) void'(frame_bytes.pop_back());
        end
    endfunction

    // mostly good replies with random content, the rest broken or plain noise
    function automatic void random_frame();
        int pick, need, n, cnt, len;
        logic [7:0] a, fn;
        t_fill fill;
        need = payload_need(active_mode());
        pick = $urandom_range(99, 0);
        a = cfg_addr;
        fn = FUNC_READ;
        n = need + $urandom_range(4, 0);
        cnt = n;
        fill = ($urandom_range(6, 0) < 5) ? FILL_RAND : t_fill'($urandom_range(4, 1));
        if (pick < 62) begin
            if ($urandom_range(6, 0) == 0) n = need + $urandom_range(59 - need, 0);
            build_frame(a, fn, 8'(n), n, fill, 1'b1, 0);
        end else if (pick < 67) begin
            a = a ^ (8'h01 << $urandom_range(7, 0));
            build_frame(a, fn, 8'(n), n, fill, $urandom_range(1, 0), 0);
        end else if (pick < 72) begin
            build_frame(a, fn, 8'(n), n, fill, 1'b0, 0);
        end else if (pick < 77) begin
            fn = 8'($urandom);
            if (fn == FUNC_READ) fn = FUNC_READ_EXCEPTION;
            build_frame(a, fn, 8'(n), n, fill, 1'b1, 0);
        end else if (pick < 82) begin
            cnt = n + $urandom_range(255 - n, 1);
            build_frame(a, fn, 8'(cnt), n, fill, 1'b1, 0);
        end else if (pick < 87) begin
            n = $urandom_range(need - 1, 0);
            build_frame(a, fn, 8'(n), n, fill, 1'b1, 0);
        end else if (pick < 90) begin
            build_frame(a, fn, 8'(n), n, fill, 1'b1, $urandom_range(5, 1));
        end else if (pick < 92) begin
            n = $urandom_range(70, 60);
            build_frame(a, fn, 8'(n), n, fill, 1'b1, 0);
        end else begin
            frame_bytes.delete();
            len = $urandom_range(24, 1);
            repeat (len) frame_bytes.push_back(8'($urandom));
            if ($urandom_range(1, 0) == 1) frame_bytes[0] = cfg_addr;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(99, 0);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
            errors++;
        end
    endfunction

    // called at a clock edge, returns at the edge where the byte is taken
    task automatic send_byte(input logic [7:0] b, input logic last_b);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        rx_ch.last_byte <= last_b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        absorb_byte(b, last_b);
        bytes_sent++;
    endtask

    task automatic send_frame(input bit typed, input t_status want);
        t_word_res r;
        for (int i = 0; i < frame_bytes.size(); i++) begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
        if (typed) begin
            r = '{value: 16'sd0, kind: 4'd0, status: want, last: 1'b1};
            expected_words.push_back(r);
        end else begin
            foreach (frame_words[k]) expected_words.push_back(frame_words[k]);
        end
        frame_words.delete();
    endtask

    task automatic quiesce();
        rx_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // both registers back to back, enable held high across the two writes
    task automatic set_config(input logic [7:0] addr, input logic [1:0] mode_sel);
        logic [7:0] mode_data;
        mode_data = {6'($urandom), mode_sel};
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_DEV_ADDR;
        i_cfg_data <= addr;
        @(posedge i_clk);
        i_cfg_index <= CFG_MODE;
        i_cfg_data <= mode_data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_addr = addr;
        cfg_mode = mode_data[1:0];
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : word_sink
        int stall, run;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = pick_stall();
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            run = ($urandom_range(9, 0) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 1);
            repeat (run) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : word_monitor
        t_word_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none actual value %h kind %0d status %0d",
                         $time, res_ch.word_value, res_ch.word_kind, res_ch.frame_status);
                errors++;
            end else begin
                want = expected_words.pop_front();
                check_field("word_value", want.value, res_ch.word_value);
                check_field("word_kind", 16'(want.kind), 16'(res_ch.word_kind));
                check_field("frame_status", 16'(want.status), 16'(res_ch.frame_status));
                check_field("last_word", 16'(want.last), 16'(res_ch.last_word));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
            else quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] a;
        logic [7:0] new_addr;
        logic [1:0] new_mode;
        rx_ch.valid <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        rx_ch.last_byte <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_DEV_ADDR;
        i_cfg_data <= 8'h00;
        i_rst_n <= 1'b0;
        errors = 0;
        bytes_sent = 0;
        steady = 0;
        cfg_addr = ADDR_RESET;
        cfg_mode = MODE_QUAT;
        clear_frame();
        foreach (word_buf[i]) word_buf[i] = 16'h0000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first rows run on the reset settings
        foreach (plan[r]) begin
            if (plan[r].mode != KEEP || plan[r].addr != KEEP) begin
                new_addr = (plan[r].addr == KEEP) ? cfg_addr : 8'(plan[r].addr);
                new_mode = (plan[r].mode == KEEP) ? cfg_mode : 2'(plan[r].mode);
                quiesce();
                set_config(new_addr, new_mode);
            end
            a = cfg_addr;
            if (plan[r].bad_addr) a = a ^ (8'h01 << $urandom_range(7, 0));
            build_frame(a, 8'(plan[r].fn), 8'(plan[r].cnt), plan[r].n, plan[r].fill,
                        plan[r].crc_ok, plan[r].trim);
            send_frame(plan[r].typed, plan[r].want);
        end

        while (bytes_sent < TOTAL_BYTES) begin
            case ($urandom_range(9, 0))
                0:       new_addr = 8'h00;
                1:       new_addr = 8'hFF;
                2, 3:    new_addr = ADDR_RESET;
                default: new_addr = 8'($urandom);
            endcase
            new_mode = 2'($urandom_range(3, 0));
            quiesce();
            set_config(new_addr, new_mode);
            steady = ($urandom_range(3, 0) == 0);
            repeat ($urandom_range(6, 3)) begin
                if (bytes_sent < TOTAL_BYTES) begin
                    random_frame();
                    send_frame(1'b0, ST_OK);
                end
            end
        end

        quiesce();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire
